// File: src/pmb_pkg.sv
// Shared types, constants and helper functions of the projection matrix builder.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package pmb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int NUM_W         = 64;
    localparam int DEN_W         = 33;
    localparam int DIV_STEP      = 2;
    localparam int DIV_STAGES    = DATA_W / DIV_STEP;
    localparam int DIV_LAT       = DIV_STAGES + 2;

    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_SECOND = 2'd1;
    localparam logic [1:0] ROW_THIRD = 2'd2;
    localparam logic [1:0] ROW_LAST  = 2'd3;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [DATA_W-1:0] l;
        logic [DATA_W-1:0] r;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] t;
        logic [DATA_W-1:0] n;
        logic [DATA_W-1:0] f;
        logic              ortho;
    } t_req;

    // One quotient job: sign of the numerator, its magnitude, signed divisor.
    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_job;

    typedef struct packed {
        logic [1:0] row;
        logic       ortho;
        logic       deg;
    } t_meta;

    function automatic logic [DATA_W-1:0] abs32(input logic [DATA_W-1:0] x);
        abs32 = x[DATA_W-1] ? (~x + 32'd1) : x;
    endfunction

    function automatic logic [DEN_W-1:0] abs33(input logic [DEN_W-1:0] x);
        abs33 = x[DEN_W-1] ? (~x + 33'd1) : x;
    endfunction

endpackage
`default_nettype wire

// File: src/pmb_qdiv.sv
// Pipelined rounding divider: sign and magnitude over a signed divisor,
// round to nearest, saturate to 32 bits. Depends on pmb_pkg.
`default_nettype none
module pmb_qdiv (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire pmb_pkg::t_job         i_job,
    output logic [pmb_pkg::DATA_W-1:0] o_q
);
    import pmb_pkg::*;

    typedef struct packed {
        logic              spec;
        logic [DATA_W-1:0] specv;
        logic              sneg;
        logic [DATA_W-1:0] dm;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] low;
        logic [DATA_W-1:0] quo;
    } t_dst;

    t_dst r_st [0:DIV_STAGES];
    t_dst n_st0;
    t_dst n_st [1:DIV_STAGES];
    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] n_q;

    // Entry stage: divisor magnitude, result sign and the cases that skip division.
    always_comb begin
        logic [DEN_W-1:0] dmag;
        logic             dneg;
        dneg = i_job.den[DEN_W-1];
        dmag = abs33(i_job.den);
        n_st0.sneg = i_job.neg ^ dneg;
        n_st0.dm   = dmag[DATA_W-1:0];
        n_st0.rem  = i_job.num[NUM_W-1:DATA_W];
        n_st0.low  = i_job.num[DATA_W-1:0];
        n_st0.quo  = '0;
        if (i_job.num == '0) begin
            n_st0.spec  = 1'b1;
            n_st0.specv = '0;
        end else if (i_job.den == '0) begin
            n_st0.spec  = 1'b1;
            n_st0.specv = i_job.neg ? SAT_MIN : SAT_MAX;
        end else if (i_job.num[NUM_W-1:DATA_W] >= dmag[DATA_W-1:0]) begin
            // The quotient reaches 2^32, so it saturates either way.
            n_st0.spec  = 1'b1;
            n_st0.specv = (i_job.neg ^ dneg) ? SAT_MIN : SAT_MAX;
        end else begin
            n_st0.spec  = 1'b0;
            n_st0.specv = '0;
        end
    end

    // Restoring division, DIV_STEP quotient bits per stage.
    always_comb begin
        logic [DATA_W:0] t;
        t = '0;
        for (int i = 1; i <= DIV_STAGES; i++) begin
            n_st[i] = r_st[i-1];
            for (int k = 0; k < DIV_STEP; k++) begin
                t = {n_st[i].rem, n_st[i].low[DATA_W-1]};
                n_st[i].low = {n_st[i].low[DATA_W-2:0], 1'b0};
                if (t >= {1'b0, n_st[i].dm}) begin
                    t = t - {1'b0, n_st[i].dm};
                    n_st[i].quo = {n_st[i].quo[DATA_W-2:0], 1'b1};
                end else begin
                    n_st[i].quo = {n_st[i].quo[DATA_W-2:0], 1'b0};
                end
                n_st[i].rem = t[DATA_W-1:0];
            end
        end
    end

    // Round half away from zero, then apply sign and saturation.
    always_comb begin
        logic            rup;
        logic [DATA_W:0] q33;
        rup = {r_st[DIV_STAGES].rem, 1'b0} >= {1'b0, r_st[DIV_STAGES].dm};
        q33 = {1'b0, r_st[DIV_STAGES].quo} + {{DATA_W{1'b0}}, rup};
        if (r_st[DIV_STAGES].spec) begin
            n_q = r_st[DIV_STAGES].specv;
        end else if (r_st[DIV_STAGES].sneg) begin
            n_q = (q33 >= 33'h0_8000_0000) ? SAT_MIN : (~q33[DATA_W-1:0] + 32'd1);
        end else begin
            n_q = (q33 > 33'h0_7FFF_FFFF) ? SAT_MAX : q33[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_st0;
            for (int i = 1; i <= DIV_STAGES; i++) begin
                r_st[i] <= n_st[i];
            end
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

// File: src/pmb_row_gen.sv
// Request holder and row sequencer: forms the two quotient jobs of each row.
// Depends on pmb_pkg.
`default_nettype none
module pmb_row_gen #(
    parameter int FRAC_BITS = pmb_pkg::FRAC_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire pmb_pkg::t_req i_req,
    input  wire logic          i_en,
    output logic               o_jvalid,
    output pmb_pkg::t_meta     o_meta,
    output pmb_pkg::t_job      o_job_a,
    output pmb_pkg::t_job      o_job_b
);
    import pmb_pkg::*;

    localparam logic [NUM_W-1:0] TWO = 64'd2 << (2 * FRAC_BITS);

    logic             r_have;
    logic [1:0]       r_row;
    logic             r_jvalid;
    logic [DEN_W-1:0] r_w, r_h, r_d, r_srl, r_stb, r_sfn;
    logic [DATA_W-1:0] r_nmag;
    logic             r_nneg;
    logic             r_fnsd;
    logic [NUM_W-1:0] r_fn2;
    logic             r_ortho;
    logic             r_deg;
    t_job             r_job_a, r_job_b;
    t_meta            r_meta;

    logic             acc;
    logic [NUM_W-1:0] n_prod;
    logic [DEN_W-1:0] n_w, n_h, n_d;
    t_job             n_a, n_b;

    assign o_ready = !r_have || (i_en && r_row == ROW_LAST);
    assign acc     = i_valid && o_ready;

    assign n_w    = {i_req.r[DATA_W-1], i_req.r} - {i_req.l[DATA_W-1], i_req.l};
    assign n_h    = {i_req.t[DATA_W-1], i_req.t} - {i_req.b[DATA_W-1], i_req.b};
    assign n_d    = {i_req.f[DATA_W-1], i_req.f} - {i_req.n[DATA_W-1], i_req.n};
    assign n_prod = 64'(abs32(i_req.f)) * 64'(abs32(i_req.n));

    always_comb begin
        logic [NUM_W-1:0] mrl, mtb, mfn, n2;
        mrl = 64'(abs33(r_srl)) << FRAC_BITS;
        mtb = 64'(abs33(r_stb)) << FRAC_BITS;
        mfn = 64'(abs33(r_sfn)) << FRAC_BITS;
        n2  = 64'(r_nmag) << (FRAC_BITS + 1);
        n_a = '0;
        n_b = '0;
        case (r_row)
            ROW_FIRST: begin
                if (r_ortho) begin
                    n_a = '{neg: 1'b0, num: TWO, den: r_w};
                    n_b = '{neg: !r_srl[DEN_W-1], num: mrl, den: r_w};
                end else begin
                    n_a = '{neg: r_nneg, num: n2, den: r_w};
                    n_b = '{neg: r_srl[DEN_W-1], num: mrl, den: r_w};
                end
            end
            ROW_SECOND: begin
                if (r_ortho) begin
                    n_a = '{neg: 1'b0, num: TWO, den: r_h};
                    n_b = '{neg: !r_stb[DEN_W-1], num: mtb, den: r_h};
                end else begin
                    n_a = '{neg: r_nneg, num: n2, den: r_h};
                    n_b = '{neg: r_stb[DEN_W-1], num: mtb, den: r_h};
                end
            end
            ROW_THIRD: begin
                if (r_ortho) begin
                    n_a = '{neg: 1'b1, num: TWO, den: r_d};
                    n_b = '{neg: !r_sfn[DEN_W-1], num: mfn, den: r_d};
                end else begin
                    n_a = '{neg: !r_sfn[DEN_W-1], num: mfn, den: r_d};
                    n_b = '{neg: !r_fnsd, num: r_fn2, den: r_d};
                end
            end
            default: begin
                // The last row is constant; zero numerators give zero quotients.
                n_a = '0;
                n_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_row    <= ROW_FIRST;
            r_jvalid <= 1'b0;
        end else begin
            if (i_en) begin
                r_jvalid <= r_have;
            end
            if (acc) begin
                r_have <= 1'b1;
                r_row  <= ROW_FIRST;
            end else if (i_en && r_have) begin
                r_row <= r_row + 2'd1;
                if (r_row == ROW_LAST) begin
                    r_have <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_w     <= n_w;
            r_h     <= n_h;
            r_d     <= n_d;
            r_srl   <= {i_req.r[DATA_W-1], i_req.r} + {i_req.l[DATA_W-1], i_req.l};
            r_stb   <= {i_req.t[DATA_W-1], i_req.t} + {i_req.b[DATA_W-1], i_req.b};
            r_sfn   <= {i_req.f[DATA_W-1], i_req.f} + {i_req.n[DATA_W-1], i_req.n};
            r_nmag  <= abs32(i_req.n);
            r_nneg  <= i_req.n[DATA_W-1];
            r_fnsd  <= i_req.f[DATA_W-1] ^ i_req.n[DATA_W-1];
            r_fn2   <= {n_prod[NUM_W-2:0], 1'b0};
            r_ortho <= i_req.ortho;
            r_deg   <= (n_w == '0) || (n_h == '0) || (n_d == '0);
        end
        if (i_en) begin
            r_job_a      <= n_a;
            r_job_b      <= n_b;
            r_meta.row   <= r_row;
            r_meta.ortho <= r_ortho;
            r_meta.deg   <= r_deg;
        end
    end

    assign o_jvalid = r_jvalid;
    assign o_meta   = r_meta;
    assign o_job_a  = r_job_a;
    assign o_job_b  = r_job_b;

endmodule
`default_nettype wire

// File: src/projection_matrix_builder_top.sv
// Top level of the projection matrix builder: row sequencer, two pipelined
// dividers and the output register. Depends on pmb_pkg, pmb_row_gen, pmb_qdiv.
`default_nettype none
// Takes one request of six planes and a mode bit and returns the 4x4 matrix
// as four row items, row 0 first, tlast on row 3. While the output is not
// stalled, the row sequencer issues one row per cycle into two pipelined
// dividers (two quotient bits per stage); a new request can be taken while the
// last row of the previous one is issued, and the output channel runs one row
// per cycle when it is not stalled. A stall on the output freezes the whole
// pipeline.
module projection_matrix_builder_top #(
    parameter int FRAC_BITS = pmb_pkg::FRAC_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    // plane_left, plane_right, plane_bottom, plane_top, plane_near, plane_far
    input  wire logic [191:0]  i_s_tdata,
    // ortho_mode
    input  wire logic [0:0]    i_s_tuser,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    // entry_col0, entry_col1, entry_col2, entry_col3
    output logic [127:0]       o_m_tdata,
    // row_index (2 bits), degenerate
    output logic [2:0]         o_m_tuser,
    output logic               o_m_tlast
);
    import pmb_pkg::*;

    localparam logic [DATA_W-1:0] ONE     = 32'(64'd1 << FRAC_BITS);
    localparam logic [DATA_W-1:0] NEG_ONE = ~ONE + 32'd1;

    t_req              req;
    logic              en;
    logic              jvalid;
    t_meta             jmeta;
    t_job              job_a, job_b;
    logic [DATA_W-1:0] qa, qb;
    logic              r_vld  [0:DIV_LAT-1];
    t_meta             r_meta [0:DIV_LAT-1];
    logic              r_ovalid;
    logic [127:0]      r_odata;
    logic [2:0]        r_ouser;
    logic              r_olast;
    logic [DATA_W-1:0] c0, c1, c2, c3;
    t_meta             tm;

    assign req.l     = i_s_tdata[31:0];
    assign req.r     = i_s_tdata[63:32];
    assign req.b     = i_s_tdata[95:64];
    assign req.t     = i_s_tdata[127:96];
    assign req.n     = i_s_tdata[159:128];
    assign req.f     = i_s_tdata[191:160];
    assign req.ortho = i_s_tuser[0];

    assign en = !r_ovalid || i_m_tready;

    pmb_row_gen #(.FRAC_BITS(FRAC_BITS)) u_gen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_req    (req),
        .i_en     (en),
        .o_jvalid (jvalid),
        .o_meta   (jmeta),
        .o_job_a  (job_a),
        .o_job_b  (job_b)
    );

    pmb_qdiv u_div_a (.i_clk(i_clk), .i_en(en), .i_job(job_a), .o_q(qa));
    pmb_qdiv u_div_b (.i_clk(i_clk), .i_en(en), .i_job(job_b), .o_q(qb));

    // Valid bits and row tags travel beside the divider stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= jvalid;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_ovalid <= r_vld[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_meta[0] <= jmeta;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_meta[i] <= r_meta[i-1];
            end
            r_odata <= {c3, c2, c1, c0};
            r_ouser <= {tm.deg, tm.row};
            r_olast <= (tm.row == ROW_LAST);
        end
    end

    // Place the two quotients of the row into their columns; the last row gets its constant entry.
    always_comb begin
        tm = r_meta[DIV_LAT-1];
        c0 = '0;
        c1 = '0;
        c2 = '0;
        c3 = '0;
        case (tm.row)
            ROW_FIRST: begin
                c0 = qa;
                if (tm.ortho) c3 = qb; else c2 = qb;
            end
            ROW_SECOND: begin
                c1 = qa;
                if (tm.ortho) c3 = qb; else c2 = qb;
            end
            ROW_THIRD: begin
                c2 = qa;
                c3 = qb;
            end
            default: begin
                if (tm.ortho) c3 = ONE; else c2 = NEG_ONE;
            end
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;
    assign o_m_tlast  = r_olast;

    a_last_on_row3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tuser[1:0] == ROW_LAST)))
        else $error("tlast does not match the row index");

    a_row3_low_cols_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[63:0] == 64'd0))
        else $error("last row carries nonzero entries in columns 0 and 1");

    a_stall_keeps_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[DIV_LAT-1] && !en) |=> r_vld[DIV_LAT-1])
        else $error("row lost in the divider pipeline during a stall");

endmodule
`default_nettype wire

// File: verif/projection_matrix_builder_top_tb.sv
// Testbench for the projection matrix builder: drives plane requests, predicts
// the four matrix rows of each and checks every row item. Depends on pmb_pkg.
`timescale 1ns / 100ps
`default_nettype none

class matrix_scoreboard;
    typedef struct {
        logic [1:0]  row;
        logic [31:0] col [4];
        logic        deg;
        logic        last;
    } row_t;

    row_t pending_rows[$];
    int   mismatches;
    int   rows_checked;
    int   requests_seen;

    function new();
        mismatches = 0;
        rows_checked = 0;
        requests_seen = 0;
    endfunction

    // Rounded quotient of a signed magnitude over a signed divisor, saturated.
    function automatic logic signed [31:0] divide_sat(bit neg, logic [65:0] num,
                                                     logic signed [33:0] den);
        logic [65:0] dm, q, rem;
        if (num == 0) return 0;
        if (den == 0) return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        dm = den < 0 ? 66'(-den) : 66'(den);
        q = num / dm;
        rem = num % dm;
        if (rem >= dm - rem) q++;
        if (den < 0) neg = !neg;
        if (neg) return q >= 66'h8000_0000 ? 32'sh8000_0000 : -32'(q);
        return q > 66'h7FFF_FFFF ? 32'sh7FFF_FFFF : 32'(q);
    endfunction

    function automatic logic signed [31:0] scaled_ratio(logic signed [33:0] x,
                                                       logic signed [33:0] den,
                                                       bit negate);
        logic [65:0] mag;
        mag = x < 0 ? 66'(-x) : 66'(x);
        return divide_sat((x < 0) != negate, mag << 16, den);
    endfunction

    function void note_request(logic [191:0] planes, bit ortho);
        logic signed [33:0] l, r, b, t, n, f, w, h, d;
        logic signed [31:0] m [4][4];
        logic [65:0] two, n2, fn2, nm, fm;
        bit fnneg, deg;
        row_t e;
        l = $signed(planes[31:0]);    r = $signed(planes[63:32]);
        b = $signed(planes[95:64]);   t = $signed(planes[127:96]);
        n = $signed(planes[159:128]); f = $signed(planes[191:160]);
        w = r - l; h = t - b; d = f - n;
        deg = (w == 0) || (h == 0) || (d == 0);
        two = 66'd2 << 32;
        foreach (m[i, j]) m[i][j] = 0;
        if (ortho) begin
            m[0][0] = divide_sat(0, two, w);
            m[0][3] = scaled_ratio(r + l, w, 1);
            m[1][1] = divide_sat(0, two, h);
            m[1][3] = scaled_ratio(t + b, h, 1);
            m[2][2] = divide_sat(1, two, d);
            m[2][3] = scaled_ratio(f + n, d, 1);
            m[3][3] = 32'sh0001_0000;
        end else begin
            nm = n < 0 ? 66'(-n) : 66'(n);
            fm = f < 0 ? 66'(-f) : 66'(f);
            n2 = (nm << 1) << 16;
            fn2 = (fm * nm) << 1;
            fnneg = ((f < 0) != (n < 0)) && fn2 != 0;
            m[0][0] = divide_sat(n < 0, n2, w);
            m[0][2] = scaled_ratio(r + l, w, 0);
            m[1][1] = divide_sat(n < 0, n2, h);
            m[1][2] = scaled_ratio(t + b, h, 0);
            m[2][2] = scaled_ratio(f + n, d, 1);
            m[2][3] = divide_sat(!fnneg, fn2, d);
            m[3][2] = -32'sh0001_0000;
        end
        for (int k = 0; k < 4; k++) begin
            e.row = 2'(k);
            for (int j = 0; j < 4; j++) e.col[j] = m[k][j];
            e.deg = deg;
            e.last = (k == 3);
            pending_rows.push_back(e);
        end
        requests_seen++;
    endfunction

    function void check_row(logic [127:0] data, logic [2:0] user, logic last);
        row_t e;
        bit bad;
        rows_checked++;
        if (pending_rows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected row item %h %h", data, user);
            return;
        end
        e = pending_rows.pop_front();
        bad = (user[1:0] !== e.row) || (user[2] !== e.deg) || (last !== e.last);
        for (int j = 0; j < 4; j++) if (data[32*j +: 32] !== e.col[j]) bad = 1;
        if (bad) begin
            mismatches++;
            if (mismatches <= 10)
                $display("row mismatch: exp row %0d cols %h %h %h %h deg %b last %b; got user %h data %h last %b",
                         e.row, e.col[0], e.col[1], e.col[2], e.col[3], e.deg, e.last,
                         user, data, last);
        end
    endfunction
endclass

module projection_matrix_builder_top_tb;
    import pmb_pkg::*;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [191:0] i_s_tdata = '0;
    logic [0:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    logic [127:0] o_m_tdata;
    logic [2:0]   o_m_tuser;
    logic         o_m_tlast;

    matrix_scoreboard rows_sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_cycles = 0;
    bit stim_done = 0;

    projection_matrix_builder_top dut (.*);

    always #5 i_clk = ~i_clk;

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_m_tready <= 0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready)
            rows_sb.check_row(o_m_tdata, o_m_tuser, o_m_tlast);
    end

    function automatic logic [31:0] rand_plane();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(20)) - 10) << 16;
            2: return {{16{1'b0}}, 16'($urandom())} ^ ($urandom_range(1) ? 32'hFFFF_0000 : 0);
            3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(2000)) - 1000) << 10;
        endcase
    endfunction

    // The valid line stays high from one item to the next unless the sender idles.
    task automatic send_request(logic [191:0] planes, bit ortho);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata <= planes;
        i_s_tuser <= ortho;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        rows_sb.note_request(planes, ortho);
    endtask

    task automatic send_planes(logic [31:0] l, r, b, t, n, f, bit ortho);
        send_request({f, n, t, b, r, l}, ortho);
    endtask

    task automatic send_random(int count);
        logic [31:0] p [6];
        int k;
        for (int i = 0; i < count; i++) begin
            foreach (p[j]) p[j] = rand_plane();
            // Now and then force a degenerate plane pair.
            if ($urandom_range(9) == 0) begin
                k = $urandom_range(2);
                p[2 * k + 1] = p[2 * k];
            end
            send_planes(p[0], p[1], p[2], p[3], p[4], p[5], $urandom_range(1));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Directed requests: usual volumes, equal planes, extremes, zeros.
        for (int m = 0; m < 2; m++) begin
            send_planes(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000,
                        32'h0001_0000, 32'h0064_0000, m);
            send_planes(32'h0002_0000, 32'h0002_0000, 32'h0, 32'h0001_0000,
                        32'h0001_0000, 32'h000A_0000, m);
            send_planes(0, 32'h0001_0000, 32'h0003_0000, 32'h0003_0000,
                        32'h0001_0000, 32'h000A_0000, m);
            send_planes(0, 32'h0001_0000, 0, 32'h0001_0000, 32'h0005_0000,
                        32'h0005_0000, m);
            send_planes(0, 0, 0, 0, 0, 0, m);
            send_planes(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, m);
            send_planes(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h8000_0000, m);
            send_planes(0, 1, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, m);
            send_planes(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_0000,
                        32'h8000_0000, m);
            send_planes(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, m);
            send_planes(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC,
                        32'h0F0F_0F0F, 32'hF0F0_F0F0, m);
        end
        send_request({192{1'b1}}, 1);
        // Let the output back up so the block stalls its input.
        hold_off_cycles <= 300;
        send_random(20);
        send_idle_pct = 7;  recv_idle_pct = 55;
        send_random(95);
        send_idle_pct = 55; recv_idle_pct = 7;
        send_random(95);
        send_idle_pct = 0;  recv_idle_pct = 0;
        send_random(95);
        i_s_tvalid <= 0;
        while (rows_sb.pending_rows.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Covered %0d requests in both modes with extremes and equal planes; %0d rows checked.",
                 rows_sb.requests_seen, rows_sb.rows_checked);
        if (rows_sb.mismatches == 0 && rows_sb.pending_rows.size() == 0) begin
            $display("projection_matrix_builder_top_tb passed");
        end else begin
            $display("%0d mismatches", rows_sb.mismatches);
            $display("projection_matrix_builder_top_tb failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("projection_matrix_builder_top_tb failed");
        $finish;
    end
endmodule

`default_nettype wire
